// File: hdl/qrv_pkg.sv
// qrv_pkg: shared types and fixed field widths for the quadratic solver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qrv_pkg;

  localparam int STATUS_W = 2;
  localparam int DISC_W   = 34;
  localparam int ROOT_W   = 35;
  localparam int VX_W     = 32;
  localparam int VY_W     = 48;

  typedef enum logic [STATUS_W-1:0] {
    ST_TWO    = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_NONE   = 2'd2,
    ST_AZERO  = 2'd3
  } status_t;

endpackage

`default_nettype wire

// File: hdl/qrv_sqrt_cell.sv
// qrv_sqrt_cell: one digit step of the pipelined integer square root
// standalone, chained by the top level
`timescale 1ns / 1ps
`default_nettype none

module qrv_sqrt_cell #(
  parameter int RTW = 33,
  parameter int RDW = 66
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [RTW+2:0] rem_i,
  input  wire logic [RTW-1:0] root_i,
  input  wire logic [RDW-1:0] rad_i,
  output logic      [RTW+2:0] rem_o,
  output logic      [RTW-1:0] root_o,
  output logic      [RDW-1:0] rad_o
);

  localparam int RMW = RTW + 3;

  logic [RMW-1:0] rem_sh;
  logic [RMW-1:0] trial;
  logic [RMW-1:0] rem_nxt;
  logic [RTW-1:0] root_nxt;
  logic [RDW-1:0] rad_nxt;
  logic [RMW-1:0] rem_r;
  logic [RTW-1:0] root_r;
  logic [RDW-1:0] rad_r;

  always_comb begin
    rem_sh  = {rem_i[RMW-3:0], rad_i[RDW-1:RDW-2]};
    trial   = {1'b0, root_i, 2'b01};
    rad_nxt = {rad_i[RDW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[RTW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[RTW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;

endmodule

`default_nettype wire

// File: hdl/qrv_div_cell.sv
// qrv_div_cell: one quotient bit of a pipelined restoring divider
// standalone, chained by the top level
`timescale 1ns / 1ps
`default_nettype none

module qrv_div_cell #(
  parameter int NW = 50,
  parameter int DW = 18
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic          neg_i,
  output logic      [DW-1:0] rem_o,
  output logic      [NW-1:0] num_o,
  output logic      [DW-1:0] den_o,
  output logic               neg_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_nxt;
  logic [NW-1:0] num_nxt;
  logic [DW-1:0] rem_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic          neg_r;

  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, den_i};
    if (trial >= {1'b0, den_i}) begin
      rem_nxt = diff[DW-1:0];
      num_nxt = {num_i[NW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DW-1:0];
      num_nxt = {num_i[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      den_r <= den_i;
      neg_r <= neg_i;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign neg_o = neg_r;

endmodule

`default_nettype wire

// File: hdl/qrv_delay.sv
// qrv_delay: enable-gated shift line that keeps side data aligned with the cell chains
// standalone
`timescale 1ns / 1ps
`default_nettype none

module qrv_delay #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] d_o
);

  logic [W-1:0] tap_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int k = 1; k < D; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign d_o = tap_r[D-1];

endmodule

`default_nettype wire

// File: hdl/quadratic_roots_vertex.sv
// quadratic_roots_vertex: discriminant, roots and vertex of a*x^2 + b*x + c
// one beat per cycle while the output is not stalled; a pipeline of the square
// root cell chain (one digit per cell) and the divider chain (one quotient bit
// per cell); the whole pipeline holds while the output is stalled
// synchronous active-low reset clears the valid pipeline only
// uses qrv_pkg, qrv_sqrt_cell, qrv_div_cell, qrv_delay
`timescale 1ns / 1ps
`default_nettype none

module quadratic_roots_vertex
  import qrv_pkg::*;
#(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] in_coef_c,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [STATUS_W-1:0]               out_status,
  output logic [DISC_W-1:0]                 out_discriminant,
  output logic [ROOT_W-1:0]                 out_root_plus,
  output logic [ROOT_W-1:0]                 out_root_minus,
  output logic [VX_W-1:0]                   out_vertex_x,
  output logic [VY_W-1:0]                   out_vertex_y
);

  localparam int CW   = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DLW  = 2 * CW + 2;
  localparam int NSQ  = CW + 1 + F;
  localparam int RDW  = 2 * NSQ;
  localparam int RMW  = NSQ + 3;
  localparam int NW   = 2 * CW + 2 + F;
  localparam int NUMW = NW + 1;
  localparam int DW   = CW + 2;
  localparam int LAT  = NSQ + NW + 5;
  localparam int EXTW = (NW + 1 > 64) ? NW + 1 : 64;
  localparam int SIDW = DLW + STATUS_W + 2 * CW;
  localparam int LATW = DLW + STATUS_W;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // input register
  logic signed [CW-1:0] a1_r, b1_r, c1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= in_coef_a;
      b1_r <= in_coef_b;
      c1_r <= in_coef_c;
    end
  end

  // products
  logic signed [2*CW-1:0] bb_nxt, ac_nxt, bb2_r, ac2_r;
  logic signed [CW-1:0]   a2_r, b2_r;

  assign bb_nxt = b1_r * b1_r;
  assign ac_nxt = a1_r * c1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bb2_r <= bb_nxt;
      ac2_r <= ac_nxt;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
    end
  end

  // discriminant and status
  logic signed [DLW-1:0] bb_x, ac_x, d_nxt, d3_r;
  status_t               st_nxt, st3_r;
  logic signed [CW-1:0]  a3_r, b3_r;

  always_comb begin
    bb_x  = DLW'(bb2_r);
    ac_x  = DLW'(ac2_r);
    d_nxt = bb_x - (ac_x <<< 2);
    if (a2_r == '0) begin
      st_nxt = ST_AZERO;
    end else if (d_nxt < 0) begin
      st_nxt = ST_NONE;
    end else if (d_nxt == '0) begin
      st_nxt = ST_DOUBLE;
    end else begin
      st_nxt = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r  <= d_nxt;
      st3_r <= st_nxt;
      a3_r  <= a2_r;
      b3_r  <= b2_r;
    end
  end

  // square root chain
  logic [RMW-1:0] sq_rem  [NSQ+1];
  logic [NSQ-1:0] sq_root [NSQ+1];
  logic [RDW-1:0] sq_rad  [NSQ+1];
  logic [DLW-1:0] d_pos;

  assign d_pos      = (d3_r < 0) ? '0 : d3_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = RDW'(d_pos) << (2 * F);

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    qrv_sqrt_cell #(
      .RTW (NSQ),
      .RDW (RDW)
    ) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .rad_o  (sq_rad[k+1])
    );
  end

  logic [SIDW-1:0] side_dl;

  qrv_delay #(
    .W (SIDW),
    .D (NSQ)
  ) u_side_dly (
    .clk (clk),
    .en  (en),
    .d_i ({d3_r, st3_r, a3_r, b3_r}),
    .d_o (side_dl)
  );

  // numerators and divisors
  logic signed [DLW-1:0]  d_dl;
  logic [STATUS_W-1:0]    st_dl;
  logic signed [CW-1:0]   a_dl, b_dl;
  logic signed [NUMW-1:0] nb_x, s_x, n_rp, n_rm, n_vx, n_vy;
  logic signed [DW-1:0]   a_x, a_mag;
  logic                   a_neg;
  logic [NW-1:0]          mag4_r [4];
  logic                   neg4_r [4];
  logic [DW-1:0]          den2_r, den4_r;
  logic [LATW-1:0]        tail4_r;

  function automatic logic [NW-1:0] mag_of(input logic signed [NUMW-1:0] v);
    logic signed [NUMW-1:0] t;
    t = (v < 0) ? -v : v;
    return t[NW-1:0];
  endfunction

  always_comb begin
    {d_dl, st_dl, a_dl, b_dl} = side_dl;
    nb_x  = -(NUMW'(b_dl) <<< F);
    s_x   = signed'(NUMW'(sq_root[NSQ]));
    n_rp  = nb_x + s_x;
    n_rm  = nb_x - s_x;
    n_vx  = nb_x;
    n_vy  = -(NUMW'(d_dl) <<< F);
    a_x   = DW'(a_dl);
    a_neg = a_dl < 0;
    a_mag = a_neg ? -a_x : a_x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r[0] <= mag_of(n_rp);
      mag4_r[1] <= mag_of(n_rm);
      mag4_r[2] <= mag_of(n_vx);
      mag4_r[3] <= mag_of(n_vy);
      neg4_r[0] <= (n_rp < 0) ^ a_neg;
      neg4_r[1] <= (n_rm < 0) ^ a_neg;
      neg4_r[2] <= (n_vx < 0) ^ a_neg;
      neg4_r[3] <= (n_vy < 0) ^ a_neg;
      den2_r    <= a_mag << 1;
      den4_r    <= a_mag << 2;
      tail4_r   <= {d_dl, st_dl};
    end
  end

  // divider chains: root_plus, root_minus, vertex_x, vertex_y
  logic [DW-1:0] dv_rem [4][NW+1];
  logic [NW-1:0] dv_num [4][NW+1];
  logic [DW-1:0] dv_den [4][NW+1];
  logic          dv_neg [4][NW+1];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    assign dv_rem[g][0] = '0;
    assign dv_num[g][0] = mag4_r[g];
    assign dv_den[g][0] = (g == 3) ? den4_r : den2_r;
    assign dv_neg[g][0] = neg4_r[g];
    for (genvar k = 0; k < NW; k++) begin : g_div
      qrv_div_cell #(
        .NW (NW),
        .DW (DW)
      ) u_cell (
        .clk   (clk),
        .en    (en),
        .rem_i (dv_rem[g][k]),
        .num_i (dv_num[g][k]),
        .den_i (dv_den[g][k]),
        .neg_i (dv_neg[g][k]),
        .rem_o (dv_rem[g][k+1]),
        .num_o (dv_num[g][k+1]),
        .den_o (dv_den[g][k+1]),
        .neg_o (dv_neg[g][k+1])
      );
    end
  end

  logic [LATW-1:0] tail_dl;

  qrv_delay #(
    .W (LATW),
    .D (NW)
  ) u_tail_dly (
    .clk (clk),
    .en  (en),
    .d_i (tail4_r),
    .d_o (tail_dl)
  );

  // output register
  logic signed [DLW-1:0]  d_o;
  status_t                st_o;
  logic signed [EXTW-1:0] q_x   [4];
  logic signed [EXTW-1:0] d_ext;
  logic                   roots_ok, vert_ok;
  logic [STATUS_W-1:0]    status_r;
  logic [DISC_W-1:0]      disc_r;
  logic [ROOT_W-1:0]      rp_r, rm_r;
  logic [VX_W-1:0]        vx_r;
  logic [VY_W-1:0]        vy_r;

  always_comb begin
    d_o      = tail_dl[LATW-1:STATUS_W];
    st_o     = status_t'(tail_dl[STATUS_W-1:0]);
    d_ext    = EXTW'(d_o);
    roots_ok = (st_o == ST_TWO) || (st_o == ST_DOUBLE);
    vert_ok  = st_o != ST_AZERO;
    for (int g = 0; g < 4; g++) begin
      q_x[g] = signed'(EXTW'(dv_num[g][NW]));
      if (dv_neg[g][NW]) begin
        q_x[g] = -q_x[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= st_o;
      disc_r   <= d_ext[DISC_W-1:0];
      rp_r     <= roots_ok ? q_x[0][ROOT_W-1:0] : '0;
      rm_r     <= roots_ok ? q_x[1][ROOT_W-1:0] : '0;
      vx_r     <= vert_ok ? q_x[2][VX_W-1:0] : '0;
      vy_r     <= vert_ok ? q_x[3][VY_W-1:0] : '0;
    end
  end

  assign out_status       = status_r;
  assign out_discriminant = disc_r;
  assign out_root_plus    = rp_r;
  assign out_root_minus   = rm_r;
  assign out_vertex_x     = vx_r;
  assign out_vertex_y     = vy_r;

  a_azero_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_AZERO |->
      out_root_plus == '0 && out_root_minus == '0 && out_vertex_x == '0 && out_vertex_y == '0)
    else $error("zero leading coefficient beat carries nonzero quotients");

  a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DOUBLE |->
      out_root_plus == out_root_minus && out_discriminant == '0)
    else $error("double root beat with unequal roots");

  a_none_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |->
      out_discriminant[DISC_W-1] && out_root_plus == '0 && out_root_minus == '0)
    else $error("no-root beat with nonnegative discriminant or roots");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> out_valid && $stable(out_vertex_y) && $stable(out_root_plus))
    else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

// File: tb/sv/quadratic_roots_vertex_tb.sv
// quadratic_roots_vertex_tb: self-checking bench for the quadratic solver
// predicts discriminant, roots, vertex and status per beat and compares in order
// depends on qrv_pkg and quadratic_roots_vertex
`timescale 1ns / 1ps

module quadratic_roots_vertex_tb;
  import qrv_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DISC_W-1:0]   disc;
    logic [ROOT_W-1:0]   rp;
    logic [ROOT_W-1:0]   rm;
    logic [VX_W-1:0]     vx;
    logic [VY_W-1:0]     vy;
  } solution_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [DISC_W-1:0] out_discriminant;
  logic [ROOT_W-1:0] out_root_plus, out_root_minus;
  logic [VX_W-1:0] out_vertex_x;
  logic [VY_W-1:0] out_vertex_y;

  solution_t pending_solutions[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  quadratic_roots_vertex u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_discriminant(out_discriminant),
    .out_root_plus(out_root_plus), .out_root_minus(out_root_minus),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned isqrt_scaled(longint unsigned d);
    longint unsigned root, rem, trial;
    root = 0;
    rem = 0;
    for (int i = CW; i >= 0; i--) begin
      rem = (rem << 2) | ((d >> (2 * i)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    for (int i = 0; i < FB; i++) begin
      rem = rem << 2;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // trunc(num * 2^FB / den), both parts truncate toward zero
  function automatic longint scaled_quot(longint num, longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    return q * (64'sd1 <<< FB) + (r * (64'sd1 <<< FB)) / den;
  endfunction

  function automatic solution_t solve_quadratic(logic signed [CW-1:0] ca,
                                                logic signed [CW-1:0] cb,
                                                logic signed [CW-1:0] cc);
    solution_t s;
    longint a, b, c, delta, sq, nb;
    a = ca;
    b = cb;
    c = cc;
    delta = b * b - 4 * a * c;
    s = '0;
    s.disc = delta[DISC_W-1:0];
    if (a == 0) begin
      s.status = ST_AZERO;
    end else begin
      s.vx = VX_W'(scaled_quot(-b, 2 * a));
      s.vy = VY_W'(scaled_quot(-delta, 4 * a));
      if (delta < 0) begin
        s.status = ST_NONE;
      end else begin
        sq = longint'(isqrt_scaled(delta));
        nb = -b * (64'sd1 <<< FB);
        s.rp = ROOT_W'((nb + sq) / (2 * a));
        if (delta == 0) begin
          s.status = ST_DOUBLE;
          s.rm = s.rp;
        end else begin
          s.status = ST_TWO;
          s.rm = ROOT_W'((nb - sq) / (2 * a));
        end
      end
    end
    return s;
  endfunction

  task automatic send_coefs(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                            logic signed [CW-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    pending_solutions.push_back(solve_quadratic(a, b, c));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [CW-1:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return CW'($signed($urandom_range(8)) - 4);
      3: return CW'($signed($urandom_range(400)) - 200);
      default: return CW'($urandom);
    endcase
  endfunction

  // receiver
  always @(posedge clk) begin
    if (rst_n) out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      solution_t got, exp_s;
      got = {out_status, out_discriminant, out_root_plus, out_root_minus,
             out_vertex_x, out_vertex_y};
      if (pending_solutions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_s = pending_solutions.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch exp %p got %p", exp_s, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("quadratic_roots_vertex verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_coefs(16'sd1, -16'sd3, 16'sd2);
    send_coefs(16'sd1, 16'sd2, 16'sd1);
    send_coefs(16'sd1, 16'sd0, 16'sd1);
    send_coefs(16'sd0, 16'sd5, 16'sd3);
    send_coefs(16'sd0, 16'sd0, 16'sd0);
    send_coefs(-16'sd2, 16'sd7, 16'sd3);
    send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
    send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff);
    send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
    send_coefs(16'sh8000, 16'sd0, 16'sh7fff);
    send_coefs(16'sh7fff, 16'sd0, 16'sh8000);
    send_coefs(16'sh7fff, 16'sh8000, 16'sd0);
    send_coefs(16'sh8000, 16'sh8000, 16'sd0);
    send_coefs(-16'sd1, -16'sd1, -16'sd1);
    send_coefs(16'sd3, 16'sd1, 16'sd0);
    send_coefs(16'sd4, 16'sd4, 16'sd1);
    send_coefs(-16'sd4, 16'sd4, -16'sd1);
    send_coefs(16'sd1, 16'sd0, -16'sd2);
  endtask

  task automatic test_random(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) begin
      logic signed [CW-1:0] a, b, c;
      a = rand_coef();
      b = rand_coef();
      c = rand_coef();
      // steer some toward double roots
      if ($urandom_range(9) == 0) begin
        a = CW'($signed($urandom_range(60)) - 30);
        b = CW'(2 * a * CW'($signed($urandom_range(20)) - 10));
        c = (a == 0) ? c : CW'((b / (2 * a)) * (b / (2 * a)) * a);
      end
      send_coefs(a, b, c);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(150, 0, 0);
    join
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(150, 0, 0);
    test_random(130, 83, 0);
    test_random(130, 0, 83);
    test_random(130, 19, 19);
    test_backpressure();
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending_solutions.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && pending_solutions.size() == 0)
      $display("quadratic_roots_vertex verification clean");
    else
      $display("quadratic_roots_vertex verification failed");
    $finish;
  end

endmodule

// File: filelist.f
hdl/qrv_pkg.sv
hdl/qrv_sqrt_cell.sv
hdl/qrv_div_cell.sv
hdl/qrv_delay.sv
hdl/quadratic_roots_vertex.sv
tb/sv/quadratic_roots_vertex_tb.sv
